// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level RTL file of the event timestamper
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clk edge, off while arst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pret_pkg.sv =====
// ----------------------------------------------------------------------------
// pret_pkg
// Types and constants of the PPS-referenced event timestamper
// ----------------------------------------------------------------------------
`default_nettype none

package pret_pkg;

	// data widths
	localparam int unsigned CntW   = 32;
	localparam int unsigned OpW    = 3;
	localparam int unsigned IdxW   = 8;
	localparam int unsigned OutW   = 176;
	localparam int unsigned AddrW  = 3;
	localparam int unsigned ApbW   = 32;

	// default stack size
	localparam int unsigned MaxEventsDef = 128;

	// register reset values
	localparam logic [CntW-1:0] PllMarginRst   = 32'd4200000;
	localparam logic [CntW-1:0] AdcIntervalRst = 32'd0;

	// register index (paddr[2])
	localparam logic RegPllMargin   = 1'b0;
	localparam logic RegAdcInterval = 1'b1;

	// event codes
	typedef enum logic [OpW-1:0] {
		OP_RAY   = 3'd0,
		OP_PPS   = 3'd1,
		OP_PLL   = 3'd2,
		OP_ADC   = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pps_referenced_event_timestamper_top.sv =====
// ----------------------------------------------------------------------------
// pps_referenced_event_timestamper_top
// Timestamps ray, PPS, PLL and ADC timer events of a free-running counter
// ----------------------------------------------------------------------------
// An item enters an input register, is decoded against the timing state by
// one level of adders and compares, and leaves through a result register:
// one item is taken every cycle, held back only while the result register
// waits on m_tready. Every item gives exactly one result. Registers (APB,
// word aligned, paddr[2] selects): 0x0 pll_margin_ticks, 0x4
// adc_interval_ticks; write them only while no item is in flight.
`default_nettype none

`include "assert_macros.svh"

module pps_referenced_event_timestamper_top #(
	parameter int unsigned MAX_EVENTS = pret_pkg::MaxEventsDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input items
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [pret_pkg::CntW-1:0]     s_tdata,   // [31:0] counter_value
	input  wire logic [pret_pkg::OpW-1:0]      s_tuser,   // [2:0] opcode
	// result items
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [31:0] period_ticks, [63:32] offset_from_pps, [95:64] event_time,
	// [103:96] event_index, [135:104] next_compare, [136] synthetic_pps,
	// [137] reference_ok, [169:138] second_count, [170] adc_trigger, rest 0
	output logic [pret_pkg::OutW-1:0]          m_tdata,
	output logic [pret_pkg::OpW-1:0]           m_tuser,   // [2:0] event_kind
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pret_pkg::AddrW-1:0]    paddr,
	input  wire logic [pret_pkg::ApbW-1:0]     pwdata,
	output logic [pret_pkg::ApbW-1:0]          prdata,
	output logic                               pready
);

	localparam logic [pret_pkg::IdxW-1:0] MaxIdx = pret_pkg::IdxW'(MAX_EVENTS);

	// configuration registers
	logic [pret_pkg::CntW-1:0] pll_margin_q;
	logic [pret_pkg::CntW-1:0] adc_interval_q;
	logic                      cfg_wr;

	// timing state
	logic [pret_pkg::CntW-1:0] last_ray_q;
	logic [pret_pkg::CntW-1:0] last_pps_q;
	logic [pret_pkg::CntW-1:0] pps_gap_q;
	logic                      pps_seen_q;
	logic                      ref_ok_q;
	logic [pret_pkg::CntW-1:0] seconds_q;
	logic [pret_pkg::CntW-1:0] etime_sum_q;
	logic [pret_pkg::IdxW-1:0] stack_depth_q;

	// input stage
	logic                      valid_s1;
	logic [pret_pkg::OpW-1:0]  opcode_s1;
	logic [pret_pkg::CntW-1:0] cv_s1;
	logic                      advance;

	// next state and result fields
	logic [pret_pkg::CntW-1:0] last_ray_d;
	logic [pret_pkg::CntW-1:0] last_pps_d;
	logic [pret_pkg::CntW-1:0] pps_gap_d;
	logic                      pps_seen_d;
	logic                      ref_ok_d;
	logic [pret_pkg::CntW-1:0] seconds_d;
	logic [pret_pkg::CntW-1:0] etime_sum_d;
	logic [pret_pkg::IdxW-1:0] stack_depth_d;
	logic [pret_pkg::CntW-1:0] period;
	logic [pret_pkg::CntW-1:0] offset;
	logic [pret_pkg::CntW-1:0] etime;
	logic [pret_pkg::IdxW-1:0] index;
	logic [pret_pkg::CntW-1:0] next_cmp;
	logic                      synth;
	logic                      adc;

	// output register
	logic                      m_valid_q;
	logic [pret_pkg::OutW-1:0] m_data_q;
	logic [pret_pkg::OpW-1:0]  m_kind_q;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		if (paddr[2] == pret_pkg::RegAdcInterval) begin
			prdata = adc_interval_q;
		end else begin
			prdata = pll_margin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll_margin_q   <= pret_pkg::PllMarginRst;
			adc_interval_q <= pret_pkg::AdcIntervalRst;
		end else if (cfg_wr) begin
			if (paddr[2] == pret_pkg::RegAdcInterval) begin
				adc_interval_q <= pwdata;
			end else begin
				pll_margin_q <= pwdata;
			end
		end
	end

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1 <= s_tuser;
			cv_s1     <= s_tdata;
		end
	end

	// event decode against current state
	always_comb begin
		last_ray_d    = last_ray_q;
		last_pps_d    = last_pps_q;
		pps_gap_d     = pps_gap_q;
		pps_seen_d    = pps_seen_q;
		ref_ok_d      = ref_ok_q;
		seconds_d     = seconds_q;
		etime_sum_d   = etime_sum_q;
		stack_depth_d = stack_depth_q;
		period        = '0;
		offset        = '0;
		etime         = '0;
		index         = '0;
		next_cmp      = '0;
		synth         = 1'b0;
		adc           = 1'b0;
		unique case (pret_pkg::op_t'(opcode_s1))
			pret_pkg::OP_RAY: begin
				period = cv_s1 - last_ray_q;
				offset = cv_s1 - last_pps_q;
				// first ray after a clear starts the running sum
				if (stack_depth_q != '0) begin
					etime_sum_d = etime_sum_q + period;
				end else begin
					etime_sum_d = period;
				end
				etime = etime_sum_d;
				index = stack_depth_q;
				if (stack_depth_q < MaxIdx) begin
					stack_depth_d = stack_depth_q + 1'b1;
				end
				last_ray_d = cv_s1;
			end
			pret_pkg::OP_PPS: begin
				seconds_d  = seconds_q + 1'b1;
				ref_ok_d   = 1'b1;
				pps_seen_d = 1'b1;
				period     = cv_s1 - last_pps_q;
				pps_gap_d  = period;
				last_pps_d = cv_s1;
				last_ray_d = cv_s1;
			end
			pret_pkg::OP_PLL: begin
				// no real pps since last match: count a synthetic second
				if (!pps_seen_q) begin
					synth     = 1'b1;
					ref_ok_d  = 1'b0;
					seconds_d = seconds_q + 1'b1;
				end
				next_cmp   = cv_s1 + pps_gap_q + pll_margin_q;
				pps_seen_d = 1'b0;
			end
			pret_pkg::OP_ADC: begin
				adc      = 1'b1;
				next_cmp = cv_s1 + adc_interval_q;
			end
			pret_pkg::OP_CLEAR: begin
				stack_depth_d = '0;
				etime_sum_d   = '0;
			end
			default: begin
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ray_q    <= '0;
			last_pps_q    <= '0;
			pps_gap_q     <= '0;
			pps_seen_q    <= 1'b0;
			ref_ok_q      <= 1'b0;
			seconds_q     <= '0;
			etime_sum_q   <= '0;
			stack_depth_q <= '0;
		end else if (advance) begin
			last_ray_q    <= last_ray_d;
			last_pps_q    <= last_pps_d;
			pps_gap_q     <= pps_gap_d;
			pps_seen_q    <= pps_seen_d;
			ref_ok_q      <= ref_ok_d;
			seconds_q     <= seconds_d;
			etime_sum_q   <= etime_sum_d;
			stack_depth_q <= stack_depth_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_kind_q <= opcode_s1;
			m_data_q <= {5'd0, adc, seconds_d, ref_ok_d, synth, next_cmp, index,
				etime, offset, period};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;

	// checks
	`ASSERT_IMPL(a_stall_blocks_input, valid_s1 && m_valid_q && !m_tready, !s_tready,
		"input taken while stage 1 is stalled")
	`ASSERT_CLK(a_stack_bounded, stack_depth_q <= MaxIdx,
		"stack depth beyond its maximum")
	`ASSERT_IMPL(a_adc_kind, m_valid_q && m_data_q[170],
		m_kind_q == pret_pkg::OP_ADC, "adc trigger on a non-adc item")
	`ASSERT_IMPL(a_result_drains, m_valid_q && m_tready && !advance, ##1 !m_valid_q,
		"result repeated after it was taken")

endmodule

`default_nettype wire
